FILE: src/multilevel_queue_scheduler_assert.svh
// Assertion macros used by the scheduler checker.
`ifndef MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define MLQS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define MLQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mlqs_pkg.sv
`default_nettype none
package mlqs_pkg;

  // Default sizing
  localparam int LEVELS_DEF      = 10;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int ID_W      = 8;
  localparam int LVL_W     = 4;
  localparam int QNT_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
  localparam logic [OP_W-1:0] OP_RELEASE  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FCFS_TOP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM  = 1'd1;

  // Configuration reset values
  localparam logic [LVL_W-1:0] FCFS_TOP_RST = 4'd4;
  localparam logic [QNT_W-1:0] QUANTUM_RST  = 8'd10;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the accepted transaction
    logic push_in;    // append latched id to latched level
    logic push_slot;  // append running id to its own level
    logic expire;     // empty the slot, flag expiry
    logic pick;       // register the chosen level
    logic pop;        // advance head of chosen level, read its entry
    logic load;       // move read entry into the slot
    logic update;     // apply tick or release
    logic out_load;   // load the result register
  } mlqs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic expire_due;
    logic pick_found;
    logic slot_valid;
    logic out_free;
  } mlqs_sts_t;

endpackage
`default_nettype wire

FILE: src/multilevel_queue_scheduler.sv
`default_nettype none
// Multilevel queue scheduler: LEVELS FIFO queues of task ids in one single-port
// memory feed one running slot; level 0 is the highest priority. Each transaction
// returns one result with the flags of the operation and the slot contents after it.
// Enqueue runs the push state and tick and release the update state, then the finish
// state loads the result into the output register. Schedule runs the expire, search,
// preempt, take and load states, skipping preempt with an empty slot and going to
// finish when the search finds no level. The controller sequences the queue memory
// one access per cycle: requeue of an expired runner, a priority search, requeue of
// a preempted runner, then a head read whose registered data is loaded into the slot.
// A new transaction is accepted once the previous result has entered the output
// register, which holds it under stall; an output stall that blocks that load keeps
// the block in the finish state. The queue memory needs no clearing pass after reset.
module multilevel_queue_scheduler
  import mlqs_pkg::*;
#(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      in_operation,
  input  wire logic [ID_W-1:0]      in_task_id,
  input  wire logic [LVL_W-1:0]     in_task_level,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_scheduled,
  output logic                      out_quantum_expired,
  output logic                      out_queue_overflow,
  output logic                      out_running_valid,
  output logic [ID_W-1:0]           out_running_id,
  output logic [LVL_W-1:0]          out_running_level,
  output logic [QNT_W-1:0]          out_running_quantum
);

  mlqs_cmd_t cmd;
  mlqs_sts_t sts;

  mlqs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  mlqs_datapath #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_operation        (in_operation),
    .in_task_id          (in_task_id),
    .in_task_level       (in_task_level),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_scheduled       (out_scheduled),
    .out_quantum_expired (out_quantum_expired),
    .out_queue_overflow  (out_queue_overflow),
    .out_running_valid   (out_running_valid),
    .out_running_id      (out_running_id),
    .out_running_level   (out_running_level),
    .out_running_quantum (out_running_quantum)
  );

endmodule
`default_nettype wire

FILE: src/mlqs_ram.sv
`default_nettype none
module mlqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: src/mlqs_ctrl.sv
`default_nettype none
module mlqs_ctrl
  import mlqs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] in_operation,
  output logic                 in_stall,
  input  wire mlqs_sts_t       sts,
  output mlqs_cmd_t            cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_EXPIRE,
    S_SEARCH,
    S_PREEMPT,
    S_TAKE,
    S_LOAD,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_operation) inside
            OP_ENQUEUE:           state_nxt = S_PUSH;
            OP_SCHEDULE:          state_nxt = S_EXPIRE;
            OP_TICK, OP_RELEASE:  state_nxt = S_UPDATE;
          endcase
        end
      end
      S_PUSH:    state_nxt = S_FINISH;
      S_EXPIRE:  state_nxt = S_SEARCH;
      S_SEARCH: begin
        if (!sts.pick_found) begin
          state_nxt = S_FINISH;
        end else if (sts.slot_valid) begin
          state_nxt = S_PREEMPT;
        end else begin
          state_nxt = S_TAKE;
        end
      end
      S_PREEMPT: state_nxt = S_TAKE;
      S_TAKE:    state_nxt = S_LOAD;
      S_LOAD:    state_nxt = S_FINISH;
      S_UPDATE:  state_nxt = S_FINISH;
      S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Commands per state
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:    cmd.capture = in_valid;
      S_PUSH:    cmd.push_in = 1'b1;
      S_EXPIRE: begin
        cmd.push_slot = sts.expire_due;
        cmd.expire    = sts.expire_due;
      end
      S_SEARCH:  cmd.pick      = 1'b1;
      S_PREEMPT: cmd.push_slot = 1'b1;
      S_TAKE:    cmd.pop       = 1'b1;
      S_LOAD:    cmd.load      = 1'b1;
      S_UPDATE:  cmd.update    = 1'b1;
      S_FINISH:  cmd.out_load  = sts.out_free;
    endcase
  end

  // Hold state and the stall output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule
`default_nettype wire

FILE: src/mlqs_datapath.sv
`default_nettype none
module mlqs_datapath
  import mlqs_pkg::*;
#(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [OP_W-1:0]      in_operation,
  input  wire logic [ID_W-1:0]      in_task_id,
  input  wire logic [LVL_W-1:0]     in_task_level,
  input  wire mlqs_cmd_t            cmd,
  output mlqs_sts_t                 sts,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_scheduled,
  output logic                      out_quantum_expired,
  output logic                      out_queue_overflow,
  output logic                      out_running_valid,
  output logic [ID_W-1:0]           out_running_id,
  output logic [LVL_W-1:0]          out_running_level,
  output logic [QNT_W-1:0]          out_running_quantum
);

  localparam int LVL_BITS = $clog2(LEVELS);
  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES  = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W   = $clog2(ENTRIES);

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  // Configuration
  logic [LVL_W-1:0] fcfs_top_r;
  logic [QNT_W-1:0] quantum_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcfs_top_r    <= FCFS_TOP_RST;
      quantum_len_r <= QUANTUM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FCFS_TOP: fcfs_top_r    <= cfg_wdata[LVL_W-1:0];
        CFG_QUANTUM:  quantum_len_r <= cfg_wdata;
      endcase
    end
  end

  // Latched transaction
  logic [OP_W-1:0]     op_r;
  logic [ID_BITS-1:0]  in_id_r;
  logic [LVL_BITS-1:0] in_lvl_r;
  logic [LVL_BITS-1:0] in_lvl_clamped;

  assign in_lvl_clamped = ({1'b0, in_task_level} >= (LVL_W + 1)'(LEVELS))
                        ? LVL_BITS'(LEVELS - 1) : LVL_BITS'(in_task_level);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_operation;
      in_id_r  <= ID_BITS'(in_task_id);
      in_lvl_r <= in_lvl_clamped;
    end
  end

  // Queue pointers and counts
  logic [PTR_W-1:0] head_r  [LEVELS];
  logic [PTR_W-1:0] tail_r  [LEVELS];
  logic [CNT_W-1:0] count_r [LEVELS];

  // Slot
  logic                slot_valid_r;
  logic [ID_BITS-1:0]  slot_id_r;
  logic [LVL_BITS-1:0] slot_level_r;
  logic [QNT_W-1:0]    slot_quantum_r;
  logic [LVL_BITS-1:0] pick_r;

  // Level being worked on this cycle
  logic                push;
  logic                push_ok;
  logic [LVL_BITS-1:0] cur_lvl;
  logic [PTR_W-1:0]    cur_head;
  logic [PTR_W-1:0]    cur_tail;
  logic [CNT_W-1:0]    cur_count;
  logic                cur_full;

  assign push      = cmd.push_in | cmd.push_slot;
  assign cur_lvl   = cmd.push_in ? in_lvl_r : (cmd.push_slot ? slot_level_r : pick_r);
  assign cur_head  = head_r[cur_lvl];
  assign cur_tail  = tail_r[cur_lvl];
  assign cur_count = count_r[cur_lvl];
  assign cur_full  = (cur_count == CNT_W'(QUEUE_DEPTH));
  assign push_ok   = push & ~cur_full;

  // Queue store
  logic [ADDR_W-1:0]  ram_addr;
  logic [ID_BITS-1:0] ram_wdata;
  logic [ID_BITS-1:0] ram_rdata;

  assign ram_addr  = ADDR_W'(ADDR_W'(cur_lvl) * ADDR_W'(QUEUE_DEPTH))
                   + ADDR_W'(cmd.pop ? cur_head : cur_tail);
  assign ram_wdata = cmd.push_in ? in_id_r : slot_id_r;

  mlqs_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Advance tail on push, head on pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (push_ok) begin
      tail_r[cur_lvl]  <= wrap_next(cur_tail);
      count_r[cur_lvl] <= CNT_W'(cur_count + 1'b1);
    end else if (cmd.pop) begin
      head_r[cur_lvl]  <= wrap_next(cur_head);
      count_r[cur_lvl] <= CNT_W'(cur_count - 1'b1);
    end
  end

  // Highest non-empty level, limited to levels above the runner
  logic                pick_found;
  logic [LVL_BITS-1:0] pick_lvl;

  always_comb begin
    pick_found = 1'b0;
    pick_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count_r[i] != '0 && (!slot_valid_r || LVL_BITS'(i) < slot_level_r)) begin
        pick_found = 1'b1;
        pick_lvl   = LVL_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      pick_r <= pick_lvl;
    end
  end

  // Slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
    end else if (cmd.expire) begin
      slot_valid_r <= 1'b0;
    end else if (cmd.load) begin
      slot_valid_r <= 1'b1;
    end else if (cmd.update && op_r == OP_RELEASE) begin
      slot_valid_r <= 1'b0;
    end
  end

  // Slot contents
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_id_r      <= ram_rdata;
      slot_level_r   <= pick_r;
      slot_quantum_r <= (LVL_W'(pick_r) > fcfs_top_r) ? quantum_len_r : '0;
    end else if (cmd.update && op_r == OP_TICK && slot_valid_r && slot_quantum_r != '0) begin
      slot_quantum_r <= slot_quantum_r - 1'b1;
    end
  end

  // Per-transaction flags
  logic sched_r, expired_r, ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.capture) begin
      sched_r   <= 1'b0;
      expired_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      if (cmd.load)          sched_r   <= 1'b1;
      if (cmd.expire)        expired_r <= 1'b1;
      if (push && cur_full)  ovf_r     <= 1'b1;
    end
  end

  // Result register
  logic              out_valid_r;
  logic              out_sched_r, out_expired_r, out_ovf_r, out_run_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic [LVL_W-1:0]  out_lvl_r;
  logic [QNT_W-1:0]  out_qnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sched_r     <= sched_r;
      out_expired_r   <= expired_r;
      out_ovf_r       <= ovf_r;
      out_run_valid_r <= slot_valid_r;
      out_id_r        <= slot_valid_r ? ID_W'(slot_id_r) : '0;
      out_lvl_r       <= slot_valid_r ? LVL_W'(slot_level_r) : '0;
      out_qnt_r       <= slot_valid_r ? slot_quantum_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_scheduled       = out_sched_r;
  assign out_quantum_expired = out_expired_r;
  assign out_queue_overflow  = out_ovf_r;
  assign out_running_valid   = out_run_valid_r;
  assign out_running_id      = out_id_r;
  assign out_running_level   = out_lvl_r;
  assign out_running_quantum = out_qnt_r;

  // Status
  assign sts.expire_due = slot_valid_r && (LVL_W'(slot_level_r) > fcfs_top_r)
                          && (slot_quantum_r == '0);
  assign sts.pick_found = pick_found;
  assign sts.slot_valid = slot_valid_r;
  assign sts.out_free   = ~out_valid_r | ~out_stall;

endmodule
`default_nettype wire

FILE: src/mlqs_checker.sv
`default_nettype none
`include "multilevel_queue_scheduler_assert.svh"
module mlqs_checker
  import mlqs_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             out_scheduled,
  input wire logic             out_running_valid,
  input wire logic [ID_W-1:0]  out_running_id,
  input wire logic [LVL_W-1:0] out_running_level,
  input wire logic [QNT_W-1:0] out_running_quantum
);

  // An empty slot reports all zero contents
  `MLQS_ASSERT_NOW(a_empty_slot_zero, out_valid && !out_running_valid, out_running_id == '0 && out_running_level == '0 && out_running_quantum == '0, "empty slot shows nonzero contents")

  // A placed task leaves the slot occupied
  `MLQS_ASSERT_NOW(a_sched_occupies, out_valid && out_scheduled, out_running_valid, "scheduled without an occupied slot")

  // The running level stays within the configured levels
  `MLQS_ASSERT_NOW(a_level_range, out_valid && out_running_valid, out_running_level <= LVL_W'(LEVELS - 1), "running level out of range")

  // An accepted transaction keeps the input side busy in the next cycle
  `MLQS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after acceptance")

  // A stalled result holds
  `MLQS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_running_id) && $stable(out_running_quantum), "stalled result changed")

endmodule

bind multilevel_queue_scheduler mlqs_checker #(
  .LEVELS (LEVELS)
) u_mlqs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_scheduled       (out_scheduled),
  .out_running_valid   (out_running_valid),
  .out_running_id      (out_running_id),
  .out_running_level   (out_running_level),
  .out_running_quantum (out_running_quantum)
);
`default_nettype wire
